// ----- hw/rtl/cpu8alu_pkg.sv -----
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Operation codes and the stage payload types of the eight-bit ALU pipeline.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    localparam int unsigned OpWidth   = 5;
    localparam int unsigned DataWidth = 8;
    localparam int unsigned IdxWidth  = 3;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_OR   = 5'd5,
        OP_XOR  = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_SWAP = 5'd10,
        OP_DAA  = 5'd11,
        OP_CPL  = 5'd12,
        OP_CCF  = 5'd13,
        OP_SCF  = 5'd14,
        OP_RLC  = 5'd15,
        OP_RL   = 5'd16,
        OP_RRC  = 5'd17,
        OP_RR   = 5'd18,
        OP_SLA  = 5'd19,
        OP_SRA  = 5'd20,
        OP_SRL  = 5'd21,
        OP_BIT  = 5'd22,
        OP_SET  = 5'd23,
        OP_RES  = 5'd24
    } op_t;

    localparam logic [DataWidth-1:0] DaaLimit = 8'h99;
    localparam logic [3:0]           NibLimit = 4'h9;

    // decoded operation, adder operands already prepared
    typedef struct packed {
        op_t                  op;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] bo;    // second adder operand, inverted for subtract
        logic                 cin;
        logic [DataWidth-1:0] mask;  // one-hot bit select
        logic                 z;
        logic                 n;
        logic                 h;
        logic                 c;     // carry, already adjusted for daa
    } dec_t;

    // computed result, zero flag still open
    typedef struct packed {
        logic [DataWidth-1:0] res;
        logic [DataWidth-1:0] zsrc;
        logic                 ztest;
        logic                 wr;
        logic                 z;
        logic                 n;
        logic                 h;
        logic                 c;
    } exe_t;

endpackage

// ----- hw/rtl/cpu8alu_decode.sv -----
// ----------------------------------------------------------------------------
// cpu8alu_decode
// First stage: operation decode, adder operand setup, decimal adjust terms.
// ----------------------------------------------------------------------------
module cpu8alu_decode (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [cpu8alu_pkg::OpWidth-1:0]        op,
    input  logic [cpu8alu_pkg::DataWidth-1:0]      operand_a,
    input  logic [cpu8alu_pkg::DataWidth-1:0]      operand_b,
    input  logic [cpu8alu_pkg::IdxWidth-1:0]       bit_index,
    input  logic                                   zero_in,
    input  logic                                   subtract_in,
    input  logic                                   half_in,
    input  logic                                   carry_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output cpu8alu_pkg::dec_t                      out_data
);
    import cpu8alu_pkg::*;

    logic                 vld_reg;
    dec_t                 data_reg;
    dec_t                 data_next;
    op_t                  opc;
    logic [DataWidth-1:0] bx;
    logic                 sub;
    logic                 t;
    logic                 daa_hi;
    logic                 daa_lo;

    assign opc = op_t'(op);

    always_comb
    begin
        t      = ((opc == OP_ADC) || (opc == OP_SBC)) ? carry_in : 1'b0;
        daa_hi = subtract_in ? carry_in : (carry_in || (operand_a > DaaLimit));
        daa_lo = subtract_in ? half_in  : (half_in || (operand_a[3:0] > NibLimit));
        bx     = operand_b;
        sub    = 1'b0;
        data_next.cin = 1'b0;
        data_next.c   = carry_in;
        unique case (opc)
            OP_ADD, OP_ADC:
            begin
                data_next.cin = t;
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                sub           = 1'b1;
                data_next.cin = ~t;
            end
            OP_INC:
            begin
                bx = DataWidth'(1);
            end
            OP_DEC:
            begin
                bx            = DataWidth'(1);
                sub           = 1'b1;
                data_next.cin = 1'b1;
            end
            OP_DAA:
            begin
                // correction 0x60 / 0x06, added after add and taken off after subtract
                bx            = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
                sub           = subtract_in;
                data_next.cin = subtract_in;
                data_next.c   = daa_hi;
            end
            default:
            begin
                bx = operand_b;
            end
        endcase
        data_next.op   = opc;
        data_next.a    = operand_a;
        data_next.bo   = sub ? ~bx : bx;
        data_next.mask = DataWidth'(1) << bit_index;
        data_next.z    = zero_in;
        data_next.n    = subtract_in;
        data_next.h    = half_in;
    end

    assign in_ready = ~vld_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/cpu8alu_exec.sv -----
// ----------------------------------------------------------------------------
// cpu8alu_exec
// Second stage: shared adder, logic and shift unit, flag selection.
// ----------------------------------------------------------------------------
module cpu8alu_exec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cpu8alu_pkg::dec_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cpu8alu_pkg::exe_t out_data
);
    import cpu8alu_pkg::*;

    logic                 vld_reg;
    exe_t                 data_reg;
    exe_t                 data_next;
    logic [DataWidth:0]   sum9;
    logic [4:0]           lo5;
    logic [DataWidth-1:0] a;
    logic                 cy;
    logic                 hc;

    assign a    = in_data.a;
    assign sum9 = {1'b0, a} + {1'b0, in_data.bo} + {{DataWidth{1'b0}}, in_data.cin};
    assign lo5  = {1'b0, a[3:0]} + {1'b0, in_data.bo[3:0]} + {4'd0, in_data.cin};
    assign cy   = sum9[DataWidth];
    assign hc   = lo5[4];

    always_comb
    begin
        data_next.res   = a;
        data_next.ztest = 1'b1;
        data_next.wr    = 1'b1;
        data_next.z     = in_data.z;
        data_next.n     = 1'b0;
        data_next.h     = 1'b0;
        data_next.c     = in_data.c;
        unique case (in_data.op)
            OP_ADD, OP_ADC:
            begin
                data_next.res = sum9[DataWidth-1:0];
                data_next.h   = hc;
                data_next.c   = cy;
            end
            OP_SUB, OP_SBC:
            begin
                // borrow is the inverted carry of a + ~b
                data_next.res = sum9[DataWidth-1:0];
                data_next.n   = 1'b1;
                data_next.h   = ~hc;
                data_next.c   = ~cy;
            end
            OP_CP:
            begin
                data_next.n  = 1'b1;
                data_next.h  = ~hc;
                data_next.c  = ~cy;
                data_next.wr = 1'b0;
            end
            OP_AND:
            begin
                data_next.res = a & in_data.bo;
                data_next.h   = 1'b1;
                data_next.c   = 1'b0;
            end
            OP_OR:
            begin
                data_next.res = a | in_data.bo;
                data_next.c   = 1'b0;
            end
            OP_XOR:
            begin
                data_next.res = a ^ in_data.bo;
                data_next.c   = 1'b0;
            end
            OP_INC:
            begin
                data_next.res = sum9[DataWidth-1:0];
                data_next.h   = hc;
            end
            OP_DEC:
            begin
                data_next.res = sum9[DataWidth-1:0];
                data_next.n   = 1'b1;
                data_next.h   = ~hc;
            end
            OP_SWAP:
            begin
                data_next.res = {a[3:0], a[7:4]};
                data_next.c   = 1'b0;
            end
            OP_DAA:
            begin
                data_next.res = sum9[DataWidth-1:0];
                data_next.n   = in_data.n;
            end
            OP_CPL:
            begin
                data_next.res   = ~a;
                data_next.n     = 1'b1;
                data_next.h     = 1'b1;
                data_next.ztest = 1'b0;
            end
            OP_CCF:
            begin
                data_next.c     = ~in_data.c;
                data_next.wr    = 1'b0;
                data_next.ztest = 1'b0;
            end
            OP_SCF:
            begin
                data_next.c     = 1'b1;
                data_next.wr    = 1'b0;
                data_next.ztest = 1'b0;
            end
            OP_RLC:
            begin
                data_next.res = {a[6:0], a[7]};
                data_next.c   = a[7];
            end
            OP_RL:
            begin
                data_next.res = {a[6:0], in_data.c};
                data_next.c   = a[7];
            end
            OP_RRC:
            begin
                data_next.res = {a[0], a[7:1]};
                data_next.c   = a[0];
            end
            OP_RR:
            begin
                data_next.res = {in_data.c, a[7:1]};
                data_next.c   = a[0];
            end
            OP_SLA:
            begin
                data_next.res = {a[6:0], 1'b0};
                data_next.c   = a[7];
            end
            OP_SRA:
            begin
                data_next.res = {a[7], a[7:1]};
                data_next.c   = a[0];
            end
            OP_SRL:
            begin
                data_next.res = {1'b0, a[7:1]};
                data_next.c   = a[0];
            end
            OP_BIT:
            begin
                data_next.z     = ~|(a & in_data.mask);
                data_next.h     = 1'b1;
                data_next.wr    = 1'b0;
                data_next.ztest = 1'b0;
            end
            OP_SET:
            begin
                data_next.res   = a | in_data.mask;
                data_next.n     = in_data.n;
                data_next.h     = in_data.h;
                data_next.ztest = 1'b0;
            end
            OP_RES:
            begin
                data_next.res   = a & ~in_data.mask;
                data_next.n     = in_data.n;
                data_next.h     = in_data.h;
                data_next.ztest = 1'b0;
            end
            default:
            begin
                // unused codes pass operand and flags through
                data_next.n     = in_data.n;
                data_next.h     = in_data.h;
                data_next.wr    = 1'b0;
                data_next.ztest = 1'b0;
            end
        endcase
        // compare tests the difference but returns the operand
        data_next.zsrc = (in_data.op == OP_CP) ? sum9[DataWidth-1:0] : data_next.res;
        if (in_data.op == OP_CP)
        begin
            data_next.ztest = 1'b1;
        end
    end

    assign in_ready = ~vld_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/cpu8alu_flags.sv -----
// ----------------------------------------------------------------------------
// cpu8alu_flags
// Third stage: zero detect, final flag merge and the output register.
// ----------------------------------------------------------------------------
module cpu8alu_flags (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cpu8alu_pkg::exe_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cpu8alu_pkg::DataWidth-1:0] result,
    output logic                              writes_result,
    output logic                              zero_out,
    output logic                              subtract_out,
    output logic                              half_out,
    output logic                              carry_out
);
    import cpu8alu_pkg::*;

    logic                 vld_reg;
    logic [DataWidth-1:0] res_reg;
    logic [3:0]           flg_reg;
    logic                 wr_reg;
    logic [3:0]           flg_next;
    logic                 z_next;

    assign z_next   = in_data.ztest ? ~|in_data.zsrc : in_data.z;
    assign flg_next = {z_next, in_data.n, in_data.h, in_data.c};

    assign in_ready = ~vld_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_data.res;
            wr_reg  <= in_data.wr;
            flg_reg <= flg_next;
        end
    end

    assign out_valid     = vld_reg;
    assign result        = res_reg;
    assign writes_result = wr_reg;
    assign zero_out      = flg_reg[3];
    assign subtract_out  = flg_reg[2];
    assign half_out      = flg_reg[1];
    assign carry_out     = flg_reg[0];

endmodule

// ----- hw/rtl/cpu_8bit_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags
// Eight-bit ALU with Z, N, H and C flag update, three register stages.
// ----------------------------------------------------------------------------
// three register stages: a transaction accepted into the decode register
// passes the exec and flags registers in turn before it can be taken at the outputs
// throughput: one transaction per cycle while res_stall is low, set by the pipeline
// a stalled output holds every stage that is full; empty stages still fill
// reset clears the stage valid bits only, no transaction is in flight after it
module cpu_8bit_alu_with_flags (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    output logic                              stall,
    input  logic [cpu8alu_pkg::OpWidth-1:0]   op,
    input  logic [cpu8alu_pkg::DataWidth-1:0] operand_a,
    input  logic [cpu8alu_pkg::DataWidth-1:0] operand_b,
    input  logic [cpu8alu_pkg::IdxWidth-1:0]  bit_index,
    input  logic                              zero_in,
    input  logic                              subtract_in,
    input  logic                              half_in,
    input  logic                              carry_in,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [cpu8alu_pkg::DataWidth-1:0] result,
    output logic                              writes_result,
    output logic                              zero_out,
    output logic                              subtract_out,
    output logic                              half_out,
    output logic                              carry_out
);
    import cpu8alu_pkg::*;

    logic in_ready;
    logic dec_valid;
    logic dec_ready;
    dec_t dec_data;
    logic exe_valid;
    logic exe_ready;
    exe_t exe_data;

    assign stall = ~in_ready;

    cpu8alu_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (valid),
        .in_ready    (in_ready),
        .op          (op),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .bit_index   (bit_index),
        .zero_in     (zero_in),
        .subtract_in (subtract_in),
        .half_in     (half_in),
        .carry_in    (carry_in),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .out_data    (dec_data)
    );

    cpu8alu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    cpu8alu_flags u_flags (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (exe_valid),
        .in_ready      (exe_ready),
        .in_data       (exe_data),
        .out_valid     (res_valid),
        .out_ready     (~res_stall),
        .result        (result),
        .writes_result (writes_result),
        .zero_out      (zero_out),
        .subtract_out  (subtract_out),
        .half_out      (half_out),
        .carry_out     (carry_out)
    );

endmodule
